// ----- rtl/core/bsp_pkg.sv -----
// ----------------------------------------------------------------------------
// bsp_pkg
// Types and codes shared by the backend selection policy block.
// ----------------------------------------------------------------------------
package bsp_pkg;

	typedef enum logic [1:0] {
		CMD_ADD        = 2'd0,
		CMD_SELECT     = 2'd1,
		CMD_RELEASE    = 2'd2,
		CMD_SET_HEALTH = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NONE      = 2'd1,
		STS_FULL      = 2'd2,
		STS_BAD_INDEX = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		STRAT_ROUND_ROBIN = 2'd0,
		STRAT_LEAST_ACTIVE = 2'd1,
		STRAT_HASH        = 2'd2,
		STRAT_WEIGHTED    = 2'd3
	} strategy_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN1,
		S_DIV,
		S_SCAN2,
		S_READ,
		S_FETCH,
		S_UPDATE,
		S_RESP
	} state_t;

	// one table entry as held in the memory
	typedef struct packed {
		logic        pool;
		logic [7:0]  weight;
		logic        health;
		logic [15:0] active;
		logic [31:0] requests;
	} entry_t;

	localparam int unsigned DIV_STEPS = 32;

endpackage

// ----- rtl/core/bsp_ram.sv -----
// ----------------------------------------------------------------------------
// bsp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/backend_selection_policy.sv -----
// ----------------------------------------------------------------------------
// backend_selection_policy
// Backend table with add, select, release and set-health commands; select
// picks a healthy backend of one pool by round robin, least active count,
// hash or weighted draw.
// ----------------------------------------------------------------------------
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------
//  command   | in_valid / in_ready   | command, malicious, hash_present, ...
//  result    | out_valid / out_ready | status, chosen_index, active_count, ...
//  config    | cfg_wr_en             | cfg_wr_data (strategy)
//
//  one command at a time. add writes the entry in S_UPDATE; release / set health
//  read the entry through S_READ, S_FETCH and S_UPDATE; select makes two passes
//  over the table memory (one read port) with a 32 step remainder unit between
//  them, or a single pass under least active count.
//  reset empties the table and clears the rotation counter; no clearing pass.
//  a result waiting in the output register does not hold off the next transfer.
// ----------------------------------------------------------------------------
module backend_selection_policy #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic        malicious,
	input  logic        hash_present,
	input  logic [31:0] client_hash,
	input  logic [31:0] random_draw,
	input  logic [3:0]  entry_index,
	input  logic        honeypot_flag,
	input  logic [7:0]  entry_weight,
	input  logic        healthy_flag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  chosen_index,
	output logic [15:0] active_count,
	output logic [31:0] request_count
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int TW = $clog2(MAX_ENTRIES + 1);
	localparam int WW = $clog2(MAX_ENTRIES * 255 + 1);
	localparam int EW = $bits(bsp_pkg::entry_t);

	bsp_pkg::state_t    state_q, state_nxt;
	bsp_pkg::strategy_t strat_q;
	logic [TW-1:0]      total_q;
	logic [31:0]        rot_q;
	logic               pend_s1;
	logic [IW-1:0]      pidx_s1;

	// latched command
	bsp_pkg::cmd_t cmd_q;
	logic          mal_q, hpres_q, hp_q, hflag_q;
	logic [31:0]   hash_q, draw_q;
	logic [3:0]    idx_q;
	logic [7:0]    wgt_q;

	// scan and divide
	logic [TW-1:0]  scan_q;
	logic [TW-1:0]  n_q;
	logic [WW-1:0]  tot_q;
	logic [15:0]    min_q;
	logic [IW-1:0]  minidx_q;
	logic           wmode_q;
	logic [31:0]    dvd_q;
	logic [WW-1:0]  dsr_q;
	logic [WW-1:0]  rem_q;
	logic [5:0]     step_q;
	logic [WW-1:0]  acc_q;
	logic [IW-1:0]  pick_q;
	bsp_pkg::entry_t rec_q;

	// staged result
	bsp_pkg::status_t res_st_q;
	logic [3:0]       res_idx_q;
	logic [15:0]      res_act_q;
	logic [31:0]      res_req_q;

	logic              out_valid_q;
	bsp_pkg::status_t  out_st_q;
	logic [3:0]        out_idx_q;
	logic [15:0]       out_act_q;
	logic [31:0]       out_req_q;

	// memory
	logic              ram_we;
	logic [IW-1:0]     ram_raddr;
	logic [EW-1:0]     ram_rdata;
	bsp_pkg::entry_t   rd_rec;
	bsp_pkg::entry_t   new_rec;

	logic          in_xfer;
	logic          scanning;
	logic          scan_done;
	logic          is_cand;
	logic          full;
	logic          bad_idx;
	logic          use_rr;
	logic          wmode;
	logic [WW:0]   div_sh;
	logic [WW-1:0] acc_add;
	logic [WW-1:0] acc_sum;
	logic          hit;
	logic          resp_go;

	bsp_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pick_q),
		.wdata(new_rec),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_rec    = bsp_pkg::entry_t'(ram_rdata);
	assign in_xfer   = in_valid && in_ready;
	assign scanning  = (state_q == bsp_pkg::S_SCAN1) || (state_q == bsp_pkg::S_SCAN2);
	assign scan_done = (scan_q == total_q) && !pend_s1;
	assign is_cand   = pend_s1 && (rd_rec.pool == mal_q) && rd_rec.health;
	assign full      = (total_q == TW'(MAX_ENTRIES));
	assign bad_idx   = (32'(idx_q) >= 32'(total_q));
	assign resp_go   = !out_valid_q || out_ready;

	// fallbacks to round robin: no hash, or all candidate weights zero
	always_comb begin
		wmode  = (strat_q == bsp_pkg::STRAT_WEIGHTED) && (tot_q != '0);
		use_rr = (strat_q == bsp_pkg::STRAT_ROUND_ROBIN)
			|| ((strat_q == bsp_pkg::STRAT_HASH) && !hpres_q)
			|| ((strat_q == bsp_pkg::STRAT_WEIGHTED) && (tot_q == '0));
	end

	assign div_sh  = {rem_q, dvd_q[31]};
	assign acc_add = wmode_q ? WW'(rd_rec.weight) : WW'(1);
	assign acc_sum = acc_q + acc_add;
	assign hit     = is_cand && (acc_sum > rem_q);

	// record written back
	always_comb begin
		new_rec = rec_q;
		unique case (cmd_q)
			bsp_pkg::CMD_ADD: begin
				new_rec.pool     = hp_q;
				new_rec.weight   = wgt_q;
				new_rec.health   = 1'b1;
				new_rec.active   = '0;
				new_rec.requests = '0;
			end
			bsp_pkg::CMD_SELECT: begin
				if (rec_q.active != 16'hffff) begin
					new_rec.active = rec_q.active + 16'd1;
				end
				new_rec.requests = rec_q.requests + 32'd1;
			end
			bsp_pkg::CMD_RELEASE: begin
				if (rec_q.active != '0) begin
					new_rec.active = rec_q.active - 16'd1;
				end
			end
			bsp_pkg::CMD_SET_HEALTH: begin
				new_rec.health = hflag_q;
			end
			default: begin
				new_rec = rec_q;
			end
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			bsp_pkg::S_IDLE: begin
				if (in_valid) state_nxt = bsp_pkg::S_DECODE;
			end
			bsp_pkg::S_DECODE: begin
				unique case (cmd_q)
					bsp_pkg::CMD_ADD:    state_nxt = full ? bsp_pkg::S_RESP : bsp_pkg::S_UPDATE;
					bsp_pkg::CMD_SELECT: state_nxt = bsp_pkg::S_SCAN1;
					default:             state_nxt = bad_idx ? bsp_pkg::S_RESP : bsp_pkg::S_READ;
				endcase
			end
			bsp_pkg::S_SCAN1: begin
				if (scan_done) begin
					if (n_q == '0) begin
						state_nxt = bsp_pkg::S_RESP;
					end else if (strat_q == bsp_pkg::STRAT_LEAST_ACTIVE) begin
						state_nxt = bsp_pkg::S_READ;
					end else begin
						state_nxt = bsp_pkg::S_DIV;
					end
				end
			end
			bsp_pkg::S_DIV: begin
				if (step_q == 6'(bsp_pkg::DIV_STEPS)) state_nxt = bsp_pkg::S_SCAN2;
			end
			bsp_pkg::S_SCAN2: begin
				if (hit) state_nxt = bsp_pkg::S_READ;
			end
			bsp_pkg::S_READ:   state_nxt = bsp_pkg::S_FETCH;
			bsp_pkg::S_FETCH:  state_nxt = bsp_pkg::S_UPDATE;
			bsp_pkg::S_UPDATE: state_nxt = bsp_pkg::S_RESP;
			bsp_pkg::S_RESP: begin
				if (resp_go) state_nxt = bsp_pkg::S_IDLE;
			end
			default: state_nxt = bsp_pkg::S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = (state_q == bsp_pkg::S_IDLE);
		ram_we    = (state_q == bsp_pkg::S_UPDATE);
		ram_raddr = scanning ? scan_q[IW-1:0] : pick_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bsp_pkg::S_IDLE;
			strat_q     <= bsp_pkg::STRAT_ROUND_ROBIN;
			total_q     <= '0;
			rot_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				strat_q <= bsp_pkg::strategy_t'(cfg_wr_data);
			end
			pend_s1 <= scanning && (scan_q != total_q);
			if ((state_q == bsp_pkg::S_UPDATE) && (cmd_q == bsp_pkg::CMD_ADD)) begin
				total_q <= total_q + TW'(1);
			end
			if ((state_q == bsp_pkg::S_SCAN1) && scan_done && (n_q != '0)
				&& (strat_q != bsp_pkg::STRAT_LEAST_ACTIVE) && use_rr) begin
				rot_q <= rot_q + 32'd1;
			end
			if ((state_q == bsp_pkg::S_RESP) && resp_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q   <= bsp_pkg::cmd_t'(command);
			mal_q   <= malicious;
			hpres_q <= hash_present;
			hash_q  <= client_hash;
			draw_q  <= random_draw;
			idx_q   <= entry_index;
			hp_q    <= honeypot_flag;
			wgt_q   <= entry_weight;
			hflag_q <= healthy_flag;
		end
		if (scanning && (scan_q != total_q)) begin
			scan_q <= scan_q + TW'(1);
		end
		pidx_s1 <= scan_q[IW-1:0];

		unique case (state_q)
			bsp_pkg::S_DECODE: begin
				scan_q    <= '0;
				n_q       <= '0;
				tot_q     <= '0;
				res_idx_q <= '0;
				res_act_q <= '0;
				res_req_q <= '0;
				if (cmd_q == bsp_pkg::CMD_ADD) begin
					pick_q   <= total_q[IW-1:0];
					res_st_q <= full ? bsp_pkg::STS_FULL : bsp_pkg::STS_OK;
				end else if (cmd_q != bsp_pkg::CMD_SELECT) begin
					pick_q   <= IW'(idx_q);
					res_st_q <= bad_idx ? bsp_pkg::STS_BAD_INDEX : bsp_pkg::STS_OK;
				end else begin
					res_st_q <= bsp_pkg::STS_OK;
				end
			end
			bsp_pkg::S_SCAN1: begin
				if (is_cand) begin
					n_q   <= n_q + TW'(1);
					tot_q <= tot_q + WW'(rd_rec.weight);
					if ((n_q == '0) || (rd_rec.active < min_q)) begin
						min_q    <= rd_rec.active;
						minidx_q <= pidx_s1;
					end
				end
				if (scan_done) begin
					pick_q  <= minidx_q;
					wmode_q <= wmode;
					step_q  <= '0;
					rem_q   <= '0;
					if (n_q == '0) res_st_q <= bsp_pkg::STS_NONE;
					if (wmode) begin
						dvd_q <= draw_q;
						dsr_q <= tot_q;
					end else begin
						dvd_q <= use_rr ? rot_q : hash_q;
						dsr_q <= WW'(n_q);
					end
				end
			end
			bsp_pkg::S_DIV: begin
				// restoring remainder, one dividend bit a cycle
				if (step_q != 6'(bsp_pkg::DIV_STEPS)) begin
					rem_q  <= (div_sh >= {1'b0, dsr_q}) ? WW'(div_sh - {1'b0, dsr_q})
						: div_sh[WW-1:0];
					dvd_q  <= {dvd_q[30:0], 1'b0};
					step_q <= step_q + 6'd1;
				end else begin
					scan_q <= '0;
					acc_q  <= '0;
				end
			end
			bsp_pkg::S_SCAN2: begin
				// weighted: first running sum above the remainder; else nth candidate
				if (is_cand) acc_q <= acc_sum;
				if (hit) pick_q <= pidx_s1;
			end
			bsp_pkg::S_FETCH: begin
				rec_q <= rd_rec;
			end
			bsp_pkg::S_UPDATE: begin
				res_idx_q <= 4'(pick_q);
				res_act_q <= new_rec.active;
				res_req_q <= new_rec.requests;
			end
			default: begin
			end
		endcase

		if ((state_q == bsp_pkg::S_RESP) && resp_go) begin
			out_st_q  <= res_st_q;
			out_idx_q <= res_idx_q;
			out_act_q <= res_act_q;
			out_req_q <= res_req_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_st_q;
	assign chosen_index  = out_idx_q;
	assign active_count  = out_act_q;
	assign request_count = out_req_q;

endmodule
